### rtl/core/madm_pkg.sv
// Shared types and constants for the motion-age frame-delay mixer.
`default_nettype none
package madm_pkg;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam int DIFFUSE_BIAS = 3;
  // frames kept in the ring; a power of two so plane arithmetic wraps naturally
  localparam int FRAME_PLANES = 32;
  localparam int AGE_W = $clog2(FRAME_PLANES);
  typedef logic [AGE_W-1:0] age_t;
endpackage
`default_nettype wire

### rtl/core/madm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module madm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/motion_age_frame_delay_mixer_core.sv
// Top level of the motion-age frame-delay mixer.
// Throughput: one pixel per clock unless m_tready stalls, limited by each RAM's single write port.
// Reset (sync, active high) starts a clearing pass over all FRAME_PLANES*MAX_WIDTH*MAX_HEIGHT
// ring entries (524288 by default) that zeroes ring and both age maps; s_tready stays low.
// Pixel transactions are held off until the pass ends; config writes are always taken.
`default_nettype none
module motion_age_frame_delay_mixer_core
  import madm_pkg::*;
#(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_HEIGHT   = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] pixel_in
  input  wire logic        s_tuser,   // [0] motion
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] pixel_out
  output logic             m_tlast,   // frame_end
  input  wire logic        cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]  cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = $clog2(FRAME_PLANES);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(CELLS);
  localparam int RING = FRAME_PLANES * CELLS;
  localparam int GW = $clog2(RING);
  localparam int CLRW = GW + 1;
  localparam int SW = 11;
  localparam logic [AGE_W-1:0] MOTION_AGE = AGE_W'(FRAME_PLANES - 1);

  // configuration
  logic [7:0] frame_width, frame_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 8'd128;
      frame_height <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end
  logic [10:0] w_eff, h_eff;
  always_comb begin
    w_eff = (frame_width < 8'd3) ? 11'd3 :
            ({3'd0, frame_width} > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : {3'd0, frame_width};
    h_eff = (frame_height < 8'd3) ? 11'd3 :
            ({3'd0, frame_height} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {3'd0, frame_height};
  end

  // clearing pass
  logic [CLRW-1:0] clr_cnt;
  logic clearing;
  assign clearing = (clr_cnt != CLRW'(RING));
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + 1'b1;
  end

  // pipeline control: stage valids v0 (position), v1 (RAM read), v2 (age), v3 (output)
  logic v1, v2, v3, adv;
  assign adv = !v3 || m_tready;
  assign s_tready = adv && !clearing;
  logic acc;
  assign acc = s_tvalid && s_tready;

  // stage 0: raster position
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [PW-1:0] write_plane;
  logic map_select;
  logic [10:0] col, row;
  logic last_col, last_row, interior;
  always_comb begin
    col = ({{(11-CW){1'b0}}, column_count} < w_eff) ? {{(11-CW){1'b0}}, column_count}
                                                    : w_eff - 11'd1;
    row = ({{(11-RW){1'b0}}, row_count} < h_eff) ? {{(11-RW){1'b0}}, row_count}
                                                 : h_eff - 11'd1;
    last_col = (col + 11'd1 >= w_eff);
    last_row = (row + 11'd1 >= h_eff);
    interior = (row >= 11'd1) && (row + 11'd2 <= h_eff) && (col >= 11'd1) &&
               (col + 11'd2 <= w_eff);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      write_plane <= '0;
      map_select <= 1'b0;
    end else if (acc) begin
      if (last_col) begin
        column_count <= '0;
        if (last_row) begin
          row_count <= '0;
          write_plane <= (write_plane == PW'(FRAME_PLANES - 1)) ? '0 : write_plane + 1'b1;
          map_select <= !map_select;
        end else row_count <= row[RW-1:0] + 1'b1;
      end else begin
        column_count <= col[CW-1:0] + 1'b1;
        row_count <= row[RW-1:0];
      end
    end
  end

  logic [AW-1:0] cell_addr;
  assign cell_addr = AW'(row[RW-1:0]) * AW'(MAX_WIDTH) + AW'(col[CW-1:0]);

  // Age maps: each of the four neighbour reads gets its own RAM copy of each map.
  // Copies k=0..3 read up, left, right, down; copy 4 is the map being written
  // (read the same cell to get the border "keep old" value).
  logic [AW-1:0] nb_addr [4];
  always_comb begin
    nb_addr[0] = cell_addr - AW'(MAX_WIDTH);
    nb_addr[1] = cell_addr - AW'(1);
    nb_addr[2] = cell_addr + AW'(1);
    nb_addr[3] = cell_addr + AW'(MAX_WIDTH);
  end
  // the age write happens in stage 2 (registered)
  logic          aw_en;
  logic [AW-1:0] aw_addr;
  age_t          aw_data;
  logic          aw_map;   // map index written
  logic [AW-1:0] clr_cell;
  assign clr_cell = clr_cnt[AW-1:0];

  age_t a_rd [2][5];
  for (genvar m = 0; m < 2; m++) begin : g_map
    for (genvar k = 0; k < 5; k++) begin : g_copy
      madm_ram #(.WIDTH(AGE_W), .DEPTH(CELLS)) u_age (
        .clk  (clk),
        .we   (clearing || (aw_en && aw_map == 1'(m))),
        .waddr(clearing ? clr_cell : aw_addr),
        .wdata(clearing ? age_t'(0) : aw_data),
        .re   (acc),
        .raddr((k < 4) ? nb_addr[k % 4] : cell_addr),
        .rdata(a_rd[m][k])
      );
    end
  end

  // stage 1 registers
  logic [31:0]   pix1;
  logic          mot1, int1, fe1, ms1;
  logic [AW-1:0] cell_addr1;
  logic [PW-1:0] wp1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= acc;
    if (adv) begin
      pix1 <= s_tdata;
      mot1 <= s_tuser;
      int1 <= interior;
      fe1 <= last_col && last_row;
      ms1 <= map_select;
      cell_addr1 <= cell_addr;
      wp1 <= write_plane;
    end
  end

  // Forwarding: a neighbour read may not yet see the writes of items still in
  // flight. Only the "next" map is written this frame and neighbours read "prev",
  // so only copy 4 (own cell, same frame) could collide; a cell is written once per
  // frame and read once per frame at the same item, so no hazard exists.
  age_t up, lf, rt, dn, old;
  logic [SW-1:0] sum, sum_adj;
  age_t new_age;
  always_comb begin
    up  = ms1 ? a_rd[1][0] : a_rd[0][0];
    lf  = ms1 ? a_rd[1][1] : a_rd[0][1];
    rt  = ms1 ? a_rd[1][2] : a_rd[0][2];
    dn  = ms1 ? a_rd[1][3] : a_rd[0][3];
    old = ms1 ? a_rd[0][4] : a_rd[1][4];
    sum = SW'(up) + SW'(lf) + SW'(rt) + SW'(dn);
    sum_adj = (sum > SW'(DIFFUSE_BIAS)) ? sum - SW'(DIFFUSE_BIAS) : sum;
    new_age = mot1 ? MOTION_AGE : (int1 ? AGE_W'(sum_adj >> 2) : old);
  end

  // stage 2: age known, write map and ring
  logic [GW-1:0] ring_raddr, ring_waddr;
  logic [PW-1:0] plane_rd;
  logic          fe2;
  logic [31:0]   pix2;
  logic          zero2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      aw_en <= 1'b0;
    end else begin
      if (adv) v2 <= v1;
      aw_en <= adv && v1;
    end
    if (adv) begin
      aw_addr <= cell_addr1;
      aw_data <= new_age;
      aw_map <= !ms1;
      fe2 <= fe1;
      pix2 <= pix1;
      zero2 <= (new_age == '0);
      // plane count is a power of two, so the subtraction wraps modulo the ring
      plane_rd <= wp1 - PW'(new_age);
      ring_waddr <= GW'(wp1) * GW'(CELLS) + GW'(cell_addr1);
    end
  end
  assign ring_raddr = GW'(plane_rd) * GW'(CELLS) + GW'(aw_addr);

  // ring read fires as the item moves into stage 3; data holds while stalled
  logic [31:0] ring_rd;
  madm_ram #(.WIDTH(32), .DEPTH(RING)) u_ring (
    .clk  (clk),
    .we   (clearing || aw_en),
    .waddr(clearing ? GW'(clr_cnt) : ring_waddr),
    .wdata(clearing ? 32'd0 : pix2),
    .re   (adv && v2),
    .raddr(ring_raddr),
    .rdata(ring_rd)
  );

  // stage 3: output register
  logic [31:0] pix3;
  logic        zero3, fe3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      pix3 <= pix2;
      zero3 <= zero2;
      fe3 <= fe2;
    end
  end
  assign m_tvalid = v3;
  assign m_tdata = zero3 ? pix3 : ring_rd;
  assign m_tlast = fe3;

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("input taken during clear");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output changed under stall");
  a_write_once: assert property (@(posedge clk) disable iff (rst)
    aw_en |-> !clearing) else $error("map write during clear");
`endif
endmodule
`default_nettype wire

### bench/tb_motion_age_frame_delay_mixer_core.sv
// Testbench for the motion-age frame-delay mixer core: scoreboard against a local predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_motion_age_frame_delay_mixer_core
  import madm_pkg::*;
();

  localparam int PLANES = 32;
  localparam int MAXW = 128;
  localparam int MAXH = 128;
  localparam int CELLS = MAXW * MAXH;
  localparam int MOTION_AGE = PLANES - 1;
  localparam int SETTLE = 12;  // extra settle time past the pipeline latency

  typedef struct packed {
    logic [31:0] pixel;
    logic        motion;
  } pix_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        frame_end;
  } delayed_pix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;     // [31:0] pixel_in
  logic        s_tuser = 1'b0;   // [0] motion
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [31:0] pixel_out
  logic        m_tlast;          // frame_end
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  motion_age_frame_delay_mixer_core dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: mirror of the frame ring, the ping-pong age maps and the raster
  bit [31:0] ring_mem [PLANES*CELLS];
  bit [4:0]  age_maps [2][CELLS];
  int        plane_wr, map_prev, col_cnt, row_cnt;
  logic [7:0] width_reg = 8'd128, height_reg = 8'd128;

  pix_item_t    pending_pix[$];
  delayed_pix_t expected_pix[$];
  int errors = 0;

  // Idle percentages per side and the long receiver hold-off request
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_go = 0;
  int hold_left = 0;
  logic in_fire = 1'b0;

  function automatic int eff_size(logic [7:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Compute the delayed pixel for one accepted transaction and advance the state.
  function automatic void predict_delay(logic [31:0] px, logic mo);
    int w, h, col, row, cell_addr, sum, nx, plane_rd;
    bit [4:0] age;
    delayed_pix_t res;
    w = eff_size(width_reg, MAXW);
    h = eff_size(height_reg, MAXH);
    // a counter beyond a shrunken size snaps to the last position
    col = (col_cnt < w) ? col_cnt : w - 1;
    row = (row_cnt < h) ? row_cnt : h - 1;
    cell_addr = row * MAXW + col;
    nx = map_prev ^ 1;
    ring_mem[plane_wr*CELLS + cell_addr] = px;
    age = age_maps[nx][cell_addr];
    // interior cells diffuse from the previous map; borders keep their old value
    if (row >= 1 && row + 2 <= h && col >= 1 && col + 2 <= w) begin
      sum = age_maps[map_prev][cell_addr-MAXW] + age_maps[map_prev][cell_addr-1]
          + age_maps[map_prev][cell_addr+1] + age_maps[map_prev][cell_addr+MAXW];
      if (sum > DIFFUSE_BIAS) sum -= DIFFUSE_BIAS;
      age = 5'(sum >> 2);
    end
    if (mo) age = 5'(MOTION_AGE);
    age_maps[nx][cell_addr] = age;
    plane_rd = (plane_wr + PLANES - int'(age)) % PLANES;
    res.pixel = ring_mem[plane_rd*CELLS + cell_addr];
    res.frame_end = 1'b0;
    if (col + 1 >= w) begin
      col_cnt = 0;
      if (row + 1 >= h) begin
        // frame end: ring plane advances, maps swap roles
        row_cnt = 0;
        res.frame_end = 1'b1;
        plane_wr = (plane_wr + 1) % PLANES;
        map_prev ^= 1;
      end else begin
        row_cnt = row + 1;
      end
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
    expected_pix.push_back(res);
  endfunction

  // Input side: sample accepted transactions and config writes at the rising edge
  always @(posedge clk) begin
    in_fire <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_delay(s_tdata, s_tuser);
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg = cfg_data;
          REG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Driver: pops pending pixels, drives at the falling edge
  always @(negedge clk) begin
    logic       nv;
    pix_item_t  it;
    nv = s_tvalid;
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || in_fire) begin
      nv = 1'b0;
      if (pending_pix.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_pix.pop_front();
        s_tdata <= it.pixel;
        s_tuser <= it.motion;
        nv = 1'b1;
      end
    end
    s_tvalid <= nv;
  end

  // Receiver ready: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each output transaction with the oldest expected pixel
  always @(posedge clk) begin
    delayed_pix_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pix.size() == 0) begin
        $error("unexpected output transaction: pixel_out=%h frame_end=%b", m_tdata, m_tlast);
        errors++;
      end else begin
        e = expected_pix.pop_front();
        if (m_tdata !== e.pixel) begin
          $error("pixel_out mismatch: expected %h actual %h", e.pixel, m_tdata);
          errors++;
        end
        if (m_tlast !== e.frame_end) begin
          $error("frame_end mismatch: expected %b actual %b", e.frame_end, m_tlast);
          errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_pix.size() > 0 || s_tvalid || expected_pix.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_size(logic [7:0] w, logic [7:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic queue_random(int n, int motion_pct);
    pix_item_t it;
    repeat (n) begin
      it.pixel = $urandom;
      it.motion = ($urandom_range(99) < motion_pct);
      pending_pix.push_back(it);
    end
  endtask

  initial begin
    pix_item_t it;
    plane_wr = 0; map_prev = 0; col_cnt = 0; row_cnt = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: 5x4 frame, field extremes, motion on and off, frame wrap
    set_size(8'd5, 8'd4);
    send_idle_pct = 10; recv_idle_pct = 46;
    for (int i = 0; i < 24; i++) begin
      case (i % 4)
        0: it.pixel = 32'h0000_0000;
        1: it.pixel = 32'hFFFF_FFFF;
        2: it.pixel = 32'hAAAA_5555;
        default: it.pixel = 32'h5555_AAAA;
      endcase
      it.motion = (i % 3 == 1);
      pending_pix.push_back(it);
    end
    wait_idle();

    // Sizes below the minimum clamp to 3x3; many short frames wrap the ring
    set_size(8'd0, 8'd1);
    queue_random(150, 15);
    wait_idle();
    set_size(8'd2, 8'd2);
    queue_random(150, 5);
    wait_idle();

    // Mid-size frame with the long receiver hold-off to fill the pipeline
    send_idle_pct = 46; recv_idle_pct = 10;
    set_size(8'd8, 8'd6);
    queue_random(250, 10);
    repeat (30) @(negedge clk);
    hold_go = 1;
    wait_idle();

    // Oversized registers clamp to the maximum, only one register large at a time
    set_size(8'd255, 8'd3);
    queue_random(200, 20);
    wait_idle();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_size(8'd4, 8'd200);
    queue_random(200, 20);
    wait_idle();

    // Back to a mid size with no idling on either side
    set_size(8'd7, 8'd5);
    queue_random(100, 30);
    wait_idle();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: long enough for the clearing pass plus the traffic, several times over
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
